[hw/rtl/bqm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqm_pkg: shared types and constants of the multiform biquad filter
// Widths, register codes, micro-op encoding and the micro-program for the
// four filter structures, plus the state-range saturation helper.
// ----------------------------------------------------------------------------
package bqm_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 28;
    localparam int GUARD_BITS     = 8;
    localparam int STATE_BITS     = SAMPLE_BITS + 2 * GUARD_BITS;

    // Five saturated products fit with room in four extra bits.
    localparam int ACC_BITS       = STATE_BITS + 4;

    // The state operand is split into two halves for the multiplier.
    localparam int MUL_LO_BITS    = STATE_BITS / 2;
    localparam int MUL_HI_BITS    = STATE_BITS - MUL_LO_BITS;
    localparam int LO_PROD_BITS   = MUL_LO_BITS + 1 + COEF_BITS;
    localparam int HI_PROD_BITS   = MUL_HI_BITS + COEF_BITS;
    localparam int PROD_BITS      = STATE_BITS + COEF_BITS;
    localparam int QUOT_BITS      = PROD_BITS - COEF_FRAC_BITS;
    localparam int WIDE_BITS      = (QUOT_BITS > ACC_BITS) ? QUOT_BITS : ACC_BITS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int PC_BITS        = 5;
    localparam int NUM_REGS       = 9;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_B0   = 3'd0,
        REG_B1   = 3'd1,
        REG_B2   = 3'd2,
        REG_A1   = 3'd3,
        REG_A2   = 3'd4,
        REG_FORM = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FORM_DF1  = 2'd0,
        FORM_DF2  = 2'd1,
        FORM_TDF1 = 2'd2,
        FORM_TDF2 = 2'd3
    } form_t;

    typedef enum logic [2:0] {
        OP_END,
        OP_ADD,
        OP_MAC,
        OP_STORE,
        OP_MOVE
    } op_t;

    typedef enum logic [3:0] {
        R_X,
        R_W,
        R_Y,
        R_MID1,
        R_MID2,
        R_IN1,
        R_IN2,
        R_OUT1,
        R_OUT2
    } reg_sel_t;

    typedef enum logic [2:0] {
        C_B0,
        C_B1,
        C_B2,
        C_A1,
        C_A2
    } coef_sel_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_EXEC,
        CORE_WAIT
    } core_state_t;

    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_LO,
        MUL_HI,
        MUL_NORM,
        MUL_DONE
    } mul_state_t;

    typedef struct packed {
        op_t       op;
        reg_sel_t  src;
        coef_sel_t coef;
        reg_sel_t  dst;
    } uop_t;

    typedef struct packed {
        logic [COEF_BITS-1:0] b0;
        logic [COEF_BITS-1:0] b1;
        logic [COEF_BITS-1:0] b2;
        logic [COEF_BITS-1:0] a1;
        logic [COEF_BITS-1:0] a2;
    } coef_set_t;

    typedef struct packed {
        logic                  start;
        logic [STATE_BITS-1:0] operand;
        logic [COEF_BITS-1:0]  coef;
    } mul_req_t;

    typedef struct packed {
        logic                  done;
        logic                  ovf;
        logic [STATE_BITS-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic [STATE_BITS-1:0] value;
        logic                  ovf;
    } sat_t;

    // Clamp a wide signed value to the state range.
    function automatic sat_t sat_state(input logic signed [WIDE_BITS-1:0] v);
        sat_t r;
        if ((&v[WIDE_BITS-1:STATE_BITS-1]) || !(|v[WIDE_BITS-1:STATE_BITS-1])) begin
            r.value = v[STATE_BITS-1:0];
            r.ovf   = 1'b0;
        end
        else begin
            r.value = {v[WIDE_BITS-1], {(STATE_BITS-1){~v[WIDE_BITS-1]}}};
            r.ovf   = 1'b1;
        end
        return r;
    endfunction

    function automatic uop_t uop_make(input op_t op, input reg_sel_t src,
                                      input coef_sel_t cf, input reg_sel_t dst);
        uop_t u;
        u.op   = op;
        u.src  = src;
        u.coef = cf;
        u.dst  = dst;
        return u;
    endfunction

    // Micro-program of each structure. The end step reads y for the output.
    function automatic uop_t uop_fetch(input form_t form, input logic [PC_BITS-1:0] pc);
        uop_t u;
        u = uop_make(OP_END, R_Y, C_B0, R_Y);
        unique case (form)
            FORM_DF1:
            begin
                case (int'(pc))
                    0: u = uop_make(OP_MAC, R_X, C_B0, R_Y);
                    1: u = uop_make(OP_MAC, R_IN1, C_B1, R_Y);
                    2: u = uop_make(OP_MAC, R_IN2, C_B2, R_Y);
                    3: u = uop_make(OP_MAC, R_OUT1, C_A1, R_Y);
                    4: u = uop_make(OP_MAC, R_OUT2, C_A2, R_Y);
                    5: u = uop_make(OP_STORE, R_Y, C_B0, R_Y);
                    6: u = uop_make(OP_MOVE, R_IN1, C_B0, R_IN2);
                    7: u = uop_make(OP_MOVE, R_X, C_B0, R_IN1);
                    8: u = uop_make(OP_MOVE, R_OUT1, C_B0, R_OUT2);
                    9: u = uop_make(OP_MOVE, R_Y, C_B0, R_OUT1);
                    default: u = uop_make(OP_END, R_Y, C_B0, R_Y);
                endcase
            end
            FORM_DF2:
            begin
                case (int'(pc))
                    0: u = uop_make(OP_ADD, R_X, C_B0, R_W);
                    1: u = uop_make(OP_MAC, R_MID1, C_A1, R_W);
                    2: u = uop_make(OP_MAC, R_MID2, C_A2, R_W);
                    3: u = uop_make(OP_STORE, R_W, C_B0, R_W);
                    4: u = uop_make(OP_MAC, R_W, C_B0, R_Y);
                    5: u = uop_make(OP_MAC, R_MID1, C_B1, R_Y);
                    6: u = uop_make(OP_MAC, R_MID2, C_B2, R_Y);
                    7: u = uop_make(OP_STORE, R_Y, C_B0, R_Y);
                    8: u = uop_make(OP_MOVE, R_MID1, C_B0, R_MID2);
                    9: u = uop_make(OP_MOVE, R_W, C_B0, R_MID1);
                    default: u = uop_make(OP_END, R_Y, C_B0, R_Y);
                endcase
            end
            FORM_TDF1:
            begin
                case (int'(pc))
                    0:  u = uop_make(OP_ADD, R_X, C_B0, R_W);
                    1:  u = uop_make(OP_ADD, R_MID2, C_B0, R_W);
                    2:  u = uop_make(OP_STORE, R_W, C_B0, R_W);
                    3:  u = uop_make(OP_MAC, R_W, C_B0, R_Y);
                    4:  u = uop_make(OP_ADD, R_IN2, C_B0, R_Y);
                    5:  u = uop_make(OP_STORE, R_Y, C_B0, R_Y);
                    6:  u = uop_make(OP_MAC, R_W, C_B1, R_IN2);
                    7:  u = uop_make(OP_ADD, R_IN1, C_B0, R_IN2);
                    8:  u = uop_make(OP_STORE, R_IN2, C_B0, R_IN2);
                    9:  u = uop_make(OP_MAC, R_W, C_A1, R_MID2);
                    10: u = uop_make(OP_ADD, R_MID1, C_B0, R_MID2);
                    11: u = uop_make(OP_STORE, R_MID2, C_B0, R_MID2);
                    12: u = uop_make(OP_MAC, R_W, C_B2, R_IN1);
                    13: u = uop_make(OP_STORE, R_IN1, C_B0, R_IN1);
                    14: u = uop_make(OP_MAC, R_W, C_A2, R_MID1);
                    15: u = uop_make(OP_STORE, R_MID1, C_B0, R_MID1);
                    default: u = uop_make(OP_END, R_Y, C_B0, R_Y);
                endcase
            end
            FORM_TDF2:
            begin
                // The old in2 is consumed by y before in2 is rewritten.
                case (int'(pc))
                    0:  u = uop_make(OP_MAC, R_X, C_B0, R_Y);
                    1:  u = uop_make(OP_ADD, R_IN2, C_B0, R_Y);
                    2:  u = uop_make(OP_STORE, R_Y, C_B0, R_Y);
                    3:  u = uop_make(OP_MAC, R_X, C_B1, R_IN2);
                    4:  u = uop_make(OP_ADD, R_IN1, C_B0, R_IN2);
                    5:  u = uop_make(OP_MAC, R_Y, C_A1, R_IN2);
                    6:  u = uop_make(OP_STORE, R_IN2, C_B0, R_IN2);
                    7:  u = uop_make(OP_MAC, R_X, C_B2, R_IN1);
                    8:  u = uop_make(OP_MAC, R_Y, C_A2, R_IN1);
                    9:  u = uop_make(OP_STORE, R_IN1, C_B0, R_IN1);
                    default: u = uop_make(OP_END, R_Y, C_B0, R_Y);
                endcase
            end
        endcase
        return u;
    endfunction

endpackage

[hw/rtl/biquad_iir_filter_multiform_unit.sv]
`timescale 1ns / 1ps
// Each accepted item runs the micro-program of the selected structure, and
// each product occupies the shared multiplier until its result returns.
// No new item is taken until the last one ends; transposed DF-I is the longest.
// The next item is taken while a finished result waits in the output register.
// Reset clears all coefficients and filter state and selects transposed DF-II.
// ----------------------------------------------------------------------------
// biquad_iir_filter_multiform_unit: second-order IIR filter, four structures
// Configuration registers feed a micro-sequenced core that shares a single
// multiplier across all products of one sample.
// ----------------------------------------------------------------------------
module biquad_iir_filter_multiform_unit
    import bqm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [SAMPLE_BITS-1:0]    sample_in,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SAMPLE_BITS-1:0]    sample_out,
    output logic                      overflow,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]      cfg_data
);

    coef_set_t coefs_reg;
    form_t     form_reg;
    logic      clear_state;
    mul_req_t  mul_req;
    mul_rsp_t  mul_rsp;

    assign cfg_ready   = 1'b1;
    // Any write of the structure register restarts the filter from zero state.
    assign clear_state = cfg_valid && (cfg_index == REG_FORM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coefs_reg <= '0;
            form_reg  <= FORM_TDF2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_B0:   coefs_reg.b0 <= cfg_data;
                REG_B1:   coefs_reg.b1 <= cfg_data;
                REG_B2:   coefs_reg.b2 <= cfg_data;
                REG_A1:   coefs_reg.a1 <= cfg_data;
                REG_A2:   coefs_reg.a2 <= cfg_data;
                REG_FORM: form_reg     <= form_t'(cfg_data[1:0]);
                default:
                begin
                end
            endcase
        end
    end

    bqm_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .overflow    (overflow),
        .coefs       (coefs_reg),
        .form        (form_reg),
        .clear_state (clear_state),
        .mul_req     (mul_req),
        .mul_rsp     (mul_rsp)
    );

    bqm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

endmodule

[hw/rtl/bqm_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqm_mul: shared coefficient multiplier
// Multiplies a state-scale value by a coefficient in two half products,
// then floors away the coefficient fraction and saturates to state range.
// ----------------------------------------------------------------------------
module bqm_mul
    import bqm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    mul_state_t state_reg;
    mul_state_t state_next;

    logic [STATE_BITS-1:0]          s_reg;
    logic [COEF_BITS-1:0]           c_reg;
    logic signed [LO_PROD_BITS-1:0] lo_reg;
    logic signed [HI_PROD_BITS-1:0] hi_reg;
    logic [STATE_BITS-1:0]          res_reg;
    logic                           ovf_reg;

    logic signed [LO_PROD_BITS-1:0] lo_prod;
    logic signed [HI_PROD_BITS-1:0] hi_prod;
    logic signed [PROD_BITS-1:0]    full_prod;
    logic signed [QUOT_BITS-1:0]    quot;
    sat_t                           quot_sat;

    // The low half is taken as unsigned, the high half carries the sign.
    assign lo_prod   = $signed({1'b0, s_reg[MUL_LO_BITS-1:0]}) * $signed(c_reg);
    assign hi_prod   = $signed(s_reg[STATE_BITS-1:MUL_LO_BITS]) * $signed(c_reg);
    assign full_prod = $signed({hi_reg, {MUL_LO_BITS{1'b0}}}) + PROD_BITS'(lo_reg);
    assign quot      = full_prod[PROD_BITS-1:COEF_FRAC_BITS];
    assign quot_sat  = sat_state(WIDE_BITS'(quot));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MUL_IDLE: if (req.start) state_next = MUL_LO;
            MUL_LO:   state_next = MUL_HI;
            MUL_HI:   state_next = MUL_NORM;
            MUL_NORM: state_next = MUL_DONE;
            MUL_DONE: state_next = MUL_IDLE;
            default:  state_next = MUL_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done    = (state_reg == MUL_DONE);
        rsp.ovf     = ovf_reg;
        rsp.product = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MUL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            MUL_IDLE:
            begin
                if (req.start)
                begin
                    s_reg <= req.operand;
                    c_reg <= req.coef;
                end
            end
            MUL_LO:   lo_reg <= lo_prod;
            MUL_HI:   hi_reg <= hi_prod;
            MUL_NORM:
            begin
                res_reg <= quot_sat.value;
                ovf_reg <= quot_sat.ovf;
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hw/rtl/bqm_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqm_core: micro-sequencer, register file and accumulator
// Runs the micro-program one step per cycle save while a product or a stalled
// output is awaited; uses the shared multiplier and holds the result register.
// ----------------------------------------------------------------------------
module bqm_core
    import bqm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SAMPLE_BITS-1:0] sample_out,
    output logic                   overflow,
    input  coef_set_t              coefs,
    input  form_t                  form,
    input  logic                   clear_state,
    output mul_req_t               mul_req,
    input  mul_rsp_t               mul_rsp
);

    localparam int RND_BITS   = STATE_BITS - GUARD_BITS + 1;
    localparam int ROUND_HALF = 1 << (GUARD_BITS - 1);

    core_state_t state_reg;
    core_state_t state_next;

    logic [PC_BITS-1:0]         pc_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic                       ovf_reg;
    logic [STATE_BITS-1:0]      rf_reg [NUM_REGS];
    logic                       out_valid_reg;
    logic [SAMPLE_BITS-1:0]     sample_out_reg;
    logic                       overflow_reg;

    uop_t                        uop;
    logic [STATE_BITS-1:0]       rd;
    logic [COEF_BITS-1:0]        coef_sel;
    logic [STATE_BITS-1:0]       x_ext;
    sat_t                        acc_sat;
    logic signed [STATE_BITS:0]  y_round;
    logic [RND_BITS-1:0]         y_scaled;
    logic [SAMPLE_BITS-1:0]      y_sample;
    logic                        y_ovf;
    logic                        out_free;
    logic                        end_fire;

    assign uop      = uop_fetch(form, pc_reg);
    assign rd       = rf_reg[uop.src];
    assign x_ext    = {{GUARD_BITS{sample_in[SAMPLE_BITS-1]}}, sample_in, {GUARD_BITS{1'b0}}};
    assign acc_sat  = sat_state(WIDE_BITS'(acc_reg));
    assign out_free = !out_valid_reg || !out_stall;
    assign end_fire = (state_reg == CORE_EXEC) && (uop.op == OP_END) && out_free;

    always_comb
    begin
        unique case (uop.coef)
            C_B0:    coef_sel = coefs.b0;
            C_B1:    coef_sel = coefs.b1;
            C_B2:    coef_sel = coefs.b2;
            C_A1:    coef_sel = coefs.a1;
            C_A2:    coef_sel = coefs.a2;
            default: coef_sel = coefs.b0;
        endcase
    end

    // Round to nearest with ties upward, then clamp to the sample range.
    assign y_round  = $signed({rd[STATE_BITS-1], rd}) + (STATE_BITS+1)'(ROUND_HALF);
    assign y_scaled = y_round[STATE_BITS:GUARD_BITS];

    always_comb
    begin
        if ((&y_scaled[RND_BITS-1:SAMPLE_BITS-1]) || !(|y_scaled[RND_BITS-1:SAMPLE_BITS-1]))
        begin
            y_sample = y_scaled[SAMPLE_BITS-1:0];
            y_ovf    = 1'b0;
        end
        else
        begin
            y_sample = {y_scaled[RND_BITS-1], {(SAMPLE_BITS-1){~y_scaled[RND_BITS-1]}}};
            y_ovf    = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (in_valid) state_next = CORE_EXEC;
            end
            CORE_EXEC:
            begin
                if (uop.op == OP_MAC) state_next = CORE_WAIT;
                else if (end_fire) state_next = CORE_IDLE;
            end
            CORE_WAIT:
            begin
                if (mul_rsp.done) state_next = CORE_EXEC;
            end
            default: state_next = CORE_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall        = (state_reg != CORE_IDLE);
        mul_req.start   = (state_reg == CORE_EXEC) && (uop.op == OP_MAC);
        mul_req.operand = rd;
        mul_req.coef    = coef_sel;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign overflow   = overflow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CORE_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (end_fire) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;

            if (clear_state)
            begin
                rf_reg[R_MID1] <= '0;
                rf_reg[R_MID2] <= '0;
                rf_reg[R_IN1]  <= '0;
                rf_reg[R_IN2]  <= '0;
                rf_reg[R_OUT1] <= '0;
                rf_reg[R_OUT2] <= '0;
            end

            unique case (state_reg)
                CORE_IDLE:
                begin
                    if (in_valid)
                    begin
                        rf_reg[R_X] <= x_ext;
                        pc_reg      <= '0;
                    end
                end
                CORE_EXEC:
                begin
                    unique case (uop.op)
                        OP_ADD:   pc_reg <= pc_reg + 1'b1;
                        OP_STORE:
                        begin
                            rf_reg[uop.dst] <= acc_sat.value;
                            pc_reg          <= pc_reg + 1'b1;
                        end
                        OP_MOVE:
                        begin
                            rf_reg[uop.dst] <= rd;
                            pc_reg          <= pc_reg + 1'b1;
                        end
                        OP_MAC:
                        begin
                        end
                        OP_END:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CORE_WAIT:
                begin
                    if (mul_rsp.done) pc_reg <= pc_reg + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (in_valid)
                begin
                    acc_reg <= '0;
                    ovf_reg <= 1'b0;
                end
            end
            CORE_EXEC:
            begin
                if (uop.op == OP_ADD)
                begin
                    acc_reg <= acc_reg + ACC_BITS'($signed(rd));
                end
                else if (uop.op == OP_STORE)
                begin
                    acc_reg <= '0;
                    ovf_reg <= ovf_reg | acc_sat.ovf;
                end
            end
            CORE_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    acc_reg <= acc_reg + ACC_BITS'($signed(mul_rsp.product));
                    ovf_reg <= ovf_reg | mul_rsp.ovf;
                end
            end
            default:
            begin
            end
        endcase

        if (end_fire)
        begin
            sample_out_reg <= y_sample;
            overflow_reg   <= ovf_reg | y_ovf;
        end
    end

endmodule

[hw/rtl/bqm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqm_port_checker: port-level checks for the multiform biquad filter
// Watches the item handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module bqm_port_checker
    import bqm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [SAMPLE_BITS-1:0] sample_out,
    input logic                   overflow
);

    // A stalled result item stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample_out) && $stable(overflow))
        else $error("result payload changed while stalled");

    // An accepted item keeps the block busy on the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an item");

    // No result can appear in the cycle after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind biquad_iir_filter_multiform_unit bqm_port_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .overflow   (overflow)
);
